>>> design/gmc_pkg.sv
package gmc_pkg;

  // Configuration register indexes and widths.
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 16;
  localparam logic [CfgIndexW-1:0] CFG_TAP_LIMIT    = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_TRAVEL_TICKS = 2'd1;

  localparam logic [7:0]  TAP_LIMIT_RESET    = 8'd6;
  localparam logic [15:0] TRAVEL_TICKS_RESET = 16'd60;
  localparam logic [7:0]  HOLD_MAX           = 8'd255;

  // Gate modes, encoded as they appear on the gate_state output.
  typedef enum logic [2:0] {
    MODE_CLOSED  = 3'd0,
    MODE_OPEN    = 3'd1,
    MODE_OPENING = 3'd2,
    MODE_CLOSING = 3'd3,
    MODE_STOPPED = 3'd4
  } gate_mode_t;

  // One result item as produced by the update logic.
  typedef struct packed {
    logic [2:0] gate_state;
    logic       green_led;
    logic       red_led;
    logic       auto_running;
  } result_t;

endpackage

>>> design/gate_motion_controller.sv
// An input item passes through the input register, then through the update logic
// into the result register, where the result item waits until it is taken at an
// edge with out_stall low.
// Throughput: one item per cycle; the input register advances whenever the
// result register is empty or being taken in the same cycle.
// Reset (rst, synchronous, active high): gate closed, counters and button history
// cleared, both registers empty, tap_limit 6 and travel_ticks 60.
module gate_motion_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gmc_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [gmc_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          open_pressed,
  input  logic                          close_pressed,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    gate_state,
  output logic                          green_led,
  output logic                          red_led,
  output logic                          auto_running
);

  logic             in_reg_valid;
  logic             in_reg_open;
  logic             in_reg_close;
  logic             advance;
  logic             process;
  logic             accept;
  gmc_pkg::result_t result;

  // The input register moves on when the result register can take an item.
  assign advance  = !out_valid || !out_stall;
  assign process  = in_reg_valid && advance;
  assign in_stall = in_reg_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (accept) begin
      in_reg_valid <= 1'b1;
    end else if (process) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg_open  <= open_pressed;
      in_reg_close <= close_pressed;
    end
  end

  // Gate state machine and configuration registers.
  gmc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (process),
    .open_now  (in_reg_open),
    .close_now (in_reg_close),
    .result    (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      gate_state   <= result.gate_state;
      green_led    <= result.green_led;
      red_led      <= result.red_led;
      auto_running <= result.auto_running;
    end
  end

endmodule

>>> design/gmc_core.sv
module gmc_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gmc_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [gmc_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          step,
  input  logic                          open_now,
  input  logic                          close_now,
  output gmc_pkg::result_t              result
);

  // Configuration registers.
  logic [7:0]  tap_limit;
  logic [15:0] travel_ticks;

  // Controller state.
  gmc_pkg::gate_mode_t gate_mode, gate_mode_next;
  logic        open_was_down, close_was_down;
  logic [7:0]  open_hold_count, open_hold_count_next;
  logic [7:0]  close_hold_count, close_hold_count_next;
  logic [15:0] travel_count, travel_count_next;
  logic        timer_active, timer_active_next;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_limit    <= gmc_pkg::TAP_LIMIT_RESET;
      travel_ticks <= gmc_pkg::TRAVEL_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gmc_pkg::CFG_TAP_LIMIT:    tap_limit    <= cfg_data[7:0];
        gmc_pkg::CFG_TRAVEL_TICKS: travel_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state: countdown first, then the open button, then the close button.
  always_comb begin
    gate_mode_next        = gate_mode;
    travel_count_next     = travel_count;
    timer_active_next     = timer_active;
    open_hold_count_next  = open_hold_count;
    close_hold_count_next = close_hold_count;

    // Travel countdown; expiry ends automatic motion.
    if (timer_active) begin
      if (travel_count <= 16'd1) begin
        timer_active_next = 1'b0;
        travel_count_next = '0;
        if (gate_mode == gmc_pkg::MODE_OPENING) begin
          gate_mode_next = gmc_pkg::MODE_OPEN;
        end else if (gate_mode == gmc_pkg::MODE_CLOSING) begin
          gate_mode_next = gmc_pkg::MODE_CLOSED;
        end
      end else begin
        travel_count_next = travel_count - 16'd1;
      end
    end

    // Open button: press starts opening, release decides tap or stop.
    if (open_now && !open_was_down) begin
      open_hold_count_next = '0;
      if (gate_mode_next == gmc_pkg::MODE_CLOSED ||
          gate_mode_next == gmc_pkg::MODE_STOPPED ||
          gate_mode_next == gmc_pkg::MODE_CLOSING) begin
        timer_active_next = 1'b0;
        travel_count_next = '0;
        gate_mode_next    = gmc_pkg::MODE_OPENING;
      end
    end else if (open_was_down) begin
      if (open_hold_count != gmc_pkg::HOLD_MAX) begin
        open_hold_count_next = open_hold_count + 8'd1;
      end
      if (!open_now && gate_mode_next == gmc_pkg::MODE_OPENING) begin
        if (open_hold_count_next <= tap_limit) begin
          timer_active_next = 1'b1;
          travel_count_next = travel_ticks;
        end else begin
          timer_active_next = 1'b0;
          travel_count_next = '0;
          gate_mode_next    = gmc_pkg::MODE_STOPPED;
        end
      end
    end

    // Close button, seeing the mode left by the open button.
    if (close_now && !close_was_down) begin
      close_hold_count_next = '0;
      if (gate_mode_next == gmc_pkg::MODE_OPEN ||
          gate_mode_next == gmc_pkg::MODE_STOPPED ||
          gate_mode_next == gmc_pkg::MODE_OPENING) begin
        timer_active_next = 1'b0;
        travel_count_next = '0;
        gate_mode_next    = gmc_pkg::MODE_CLOSING;
      end
    end else if (close_was_down) begin
      if (close_hold_count != gmc_pkg::HOLD_MAX) begin
        close_hold_count_next = close_hold_count + 8'd1;
      end
      if (!close_now && gate_mode_next == gmc_pkg::MODE_CLOSING) begin
        if (close_hold_count_next <= tap_limit) begin
          timer_active_next = 1'b1;
          travel_count_next = travel_ticks;
        end else begin
          timer_active_next = 1'b0;
          travel_count_next = '0;
          gate_mode_next    = gmc_pkg::MODE_STOPPED;
        end
      end
    end
  end

  // Result item seen after this tick's update.
  always_comb begin
    result.gate_state   = gate_mode_next;
    result.green_led    = (gate_mode_next == gmc_pkg::MODE_OPENING);
    result.red_led      = (gate_mode_next == gmc_pkg::MODE_CLOSING);
    result.auto_running = timer_active_next;
  end

  // State registers advance once per processed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_mode        <= gmc_pkg::MODE_CLOSED;
      open_was_down    <= 1'b0;
      close_was_down   <= 1'b0;
      open_hold_count  <= '0;
      close_hold_count <= '0;
      travel_count     <= '0;
      timer_active     <= 1'b0;
    end else if (step) begin
      gate_mode        <= gate_mode_next;
      open_was_down    <= open_now;
      close_was_down   <= close_now;
      open_hold_count  <= open_hold_count_next;
      close_hold_count <= close_hold_count_next;
      travel_count     <= travel_count_next;
      timer_active     <= timer_active_next;
    end
  end

endmodule
